// ----- rtl/dnsq_pkg.sv -----
package dnsq_pkg;

	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int MAX_BITS_DEF     = 24;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam int GEN_W       = 32;
	localparam int STEP_W      = 32;
	localparam int REACH_W     = 23;
	localparam int BITS_W      = 5;
	localparam int MODE_W      = 2;
	localparam int DIV_W       = STEP_W + 1;
	localparam int EXTRA_FRAC  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_ENABLED   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BIT_COUNT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_REACH     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SEED      = 3'd4;

	localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DITHER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHAPED = 2'd2;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	localparam logic               ENABLED_RST = 1'b0;
	localparam logic [MODE_W-1:0]  MODE_RST    = MODE_DITHER;
	localparam logic [BITS_W-1:0]  BITS_RST    = 5'd16;
	localparam logic [REACH_W-1:0] REACH_RST   = 23'd1048576;
	localparam logic [GEN_W-1:0]   GEN_RST     = 32'd1;
	localparam logic [STEP_W-1:0]  STEP_RST    = 32'd8192;

	typedef struct packed {
		logic busy;
		logic done;
	} dnsq_div_stat_t;

	function automatic logic [GEN_W-1:0] xs32(input logic [GEN_W-1:0] g);
		logic [GEN_W-1:0] a;
		logic [GEN_W-1:0] b;
		a = g ^ (g << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

endpackage

// ----- rtl/dnsq_if.sv -----
interface dnsq_in_if import dnsq_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, output kind, output sample, input ready);
	modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface dnsq_out_if import dnsq_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] quantised;

	modport source (output valid, output quantised, input ready);
	modport sink   (input valid, input quantised, output ready);
endinterface

interface dnsq_cfg_if import dnsq_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/dnsq_rem_unit.sv -----
module dnsq_rem_unit import dnsq_pkg::*; #(
	parameter int NUM_W = 38
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DIV_W-1:0] divisor,
	output dnsq_div_stat_t   stat,
	output logic [DIV_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DIV_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, divisor};
	assign ge      = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

	a_busy_excl_done: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !stat.done)
		else $error("remainder unit busy and done together");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done && !start |=> !stat.done)
		else $error("remainder unit done held longer than one cycle");

endmodule

// ----- rtl/dithered_noise_shaped_quantiser.sv -----
// Requantiser for signed Q3.20 samples with optional triangular dither and
// first-order error-feedback noise shaping.
// Channels: items (kind, sample) in, results (quantised) out, cfg (index,
// data) for register writes. All move one transaction per edge at which
// valid and ready are both high. cfg is always ready; write it only while
// no item is in flight.
// A clear item (kind = 1) zeroes the carried error as it is taken and gives
// no result. A sample item gives exactly one result.
// Timing: an item is taken only in the idle state. Disabled, a sample goes
// straight to the output state. Enabled, the remainder loop dominates: it
// retires one numerator bit per cycle over N = 3 + max(SAMPLE_WIDTH+11, 35)
// bits (38 at the default width). Dither modes step through draw1, draw2,
// mul, prep, start, div, fix, round, clamp and out; plain mode starts at
// prep, and a zero step goes from prep to clamp. The next item can be taken
// in the cycle after the result is loaded, not before.
// The result sits in an output register; a stalled receiver holds the
// sequencer in its final state until that register frees, while already
// delivered results are not touched.
// Reset: registers return to disabled, dither mode, 16 bits, reach 1.0,
// generator 1, carried error 0, no result pending.
module dithered_noise_shaped_quantiser import dnsq_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int MAX_BITS     = MAX_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dnsq_cfg_if.sink    cfg,
	dnsq_in_if.sink     items,
	dnsq_out_if.source  results
);

	localparam int CARRY_W  = SAMPLE_WIDTH + 2;
	localparam int GO_W     = SAMPLE_WIDTH + 3;
	localparam int DSUM_W   = 26;
	localparam int PROD_W   = DSUM_W + STEP_W + 1;
	localparam int DSHIFT   = 24;
	localparam int DITH_W   = PROD_W - DSHIFT;
	localparam int V_W      = ((GO_W + EXTRA_FRAC) > DITH_W ? (GO_W + EXTRA_FRAC) : DITH_W) + 1;
	localparam int NUM_W    = V_W + 2;
	localparam int ANS_W    = NUM_W - EXTRA_FRAC;
	localparam int ERR_W    = ANS_W + 1;
	localparam int DRAW_LO  = GEN_W - 24;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_DRAW1 = 11'b00000000010,
		S_DRAW2 = 11'b00000000100,
		S_MUL   = 11'b00000001000,
		S_PREP  = 11'b00000010000,
		S_START = 11'b00000100000,
		S_DIV   = 11'b00001000000,
		S_FIX   = 11'b00010000000,
		S_ROUND = 11'b00100000000,
		S_CLAMP = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t                    state_q;
	logic                      enabled_q;
	logic [MODE_W-1:0]         mode_q;
	logic [BITS_W-1:0]         bits_q;
	logic [REACH_W-1:0]        reach_q;
	logic [GEN_W-1:0]          gen_q;
	logic signed [CARRY_W-1:0] carried_q;
	logic [STEP_W-1:0]         step_q;
	logic                      shape_q;
	logic                      out_valid_q;
	logic [SAMPLE_WIDTH-1:0]   out_data_q;

	logic signed [GO_W-1:0]    going_q;
	logic [GEN_W-DRAW_LO-1:0]  d1_q;
	logic signed [DSUM_W-1:0]  dsum_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [NUM_W-1:0]   n_q;
	logic                      neg_q;
	logic [DIV_W-1:0]          r_q;
	logic signed [ANS_W-1:0]   ans_q;
	logic signed [ANS_W-1:0]   res_q;

	logic                      cfg_wr;
	logic                      redesign;
	logic                      seed_wr;
	logic                      en_n;
	logic [MODE_W-1:0]         mode_n;
	logic [BITS_W-1:0]         bits_n;
	logic [REACH_W-1:0]        reach_n;
	logic [GEN_W-1:0]          seed_n;
	logic [REACH_W+EXTRA_FRAC-1:0] reach_sh;
	logic [STEP_W-1:0]         step_n;

	logic                      item_acc;
	logic                      clr_acc;
	logic                      smp_acc;
	logic signed [SAMPLE_WIDTH-1:0] sample_s;
	logic signed [GO_W-1:0]    going_n;
	logic [GEN_W-1:0]          gen_next;
	logic signed [DSUM_W-1:0]  dsum_n;
	logic signed [DIV_W-1:0]   step_sx;
	logic signed [DITH_W-1:0]  dither;
	logic signed [NUM_W-1:0]   n_n;
	logic [NUM_W-1:0]          num_mag;
	logic [DIV_W-1:0]          divisor;
	logic [DIV_W-1:0]          rem;
	logic [DIV_W-1:0]          r_n;
	logic signed [NUM_W:0]     t_full;
	logic signed [NUM_W:0]     t_sh;
	logic signed [ANS_W-1:0]   reach_s;
	logic signed [ANS_W-1:0]   clamp_n;
	logic signed [ERR_W-1:0]   err;
	logic signed [CARRY_W-1:0] err_sat;
	logic                      out_load;
	logic                      div_start;
	dnsq_div_stat_t            div_stat;

	assign cfg_wr    = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		en_n     = enabled_q;
		mode_n   = mode_q;
		bits_n   = bits_q;
		reach_n  = reach_q;
		seed_n   = gen_q;
		redesign = 1'b0;
		seed_wr  = 1'b0;
		if (cfg_wr) begin
			unique case (cfg.index)
				REG_ENABLED: begin
					en_n     = cfg.data[0];
					redesign = 1'b1;
				end
				REG_MODE: begin
					if (cfg.data[MODE_W-1:0] <= MODE_SHAPED) begin
						mode_n   = cfg.data[MODE_W-1:0];
						redesign = 1'b1;
					end
				end
				REG_BIT_COUNT: begin
					if (cfg.data[BITS_W-1:0] != '0 &&
					    32'(cfg.data[BITS_W-1:0]) <= 32'(MAX_BITS)) begin
						bits_n   = cfg.data[BITS_W-1:0];
						redesign = 1'b1;
					end
				end
				REG_REACH: begin
					if (cfg.data[REACH_W-1:0] != '0) begin
						reach_n  = cfg.data[REACH_W-1:0];
						redesign = 1'b1;
					end
				end
				REG_SEED: begin
					seed_n  = (cfg.data == '0) ? GEN_RST : cfg.data;
					seed_wr = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign reach_sh = {reach_n, {EXTRA_FRAC{1'b0}}} >> (bits_n - BITS_W'(1));
	assign step_n   = STEP_W'(reach_sh);

	assign items.ready = (state_q == S_IDLE);
	assign item_acc    = items.valid && items.ready;
	assign clr_acc     = item_acc && (items.kind == KIND_CLEAR);
	assign smp_acc     = item_acc && (items.kind == KIND_SAMPLE);
	assign sample_s    = items.sample;
	assign going_n     = GO_W'(sample_s) -
	                     ((mode_q == MODE_SHAPED) ? GO_W'(carried_q) : GO_W'(0));

	assign gen_next = xs32(gen_q);
	assign dsum_n   = $signed({2'b00, d1_q}) + $signed({2'b00, gen_next[GEN_W-1:DRAW_LO]})
	                  - $signed(DSUM_W'(1 << 24));
	assign step_sx  = $signed({1'b0, step_q});
	assign dither   = prod_q[PROD_W-1:DSHIFT];
	assign n_n      = (NUM_W'(going_q) <<< (EXTRA_FRAC + 1)) + (NUM_W'(dither) <<< 1)
	                  + NUM_W'(step_sx);
	assign num_mag  = n_q[NUM_W-1] ? NUM_W'(-n_q) : NUM_W'(n_q);
	assign divisor  = {step_q, 1'b0};
	assign r_n      = (neg_q && rem != '0) ? (divisor - rem) : rem;
	assign t_full   = (NUM_W+1)'(n_q) - $signed({{(NUM_W+1-DIV_W){1'b0}}, r_q})
	                  + $signed((NUM_W+1)'(1 << EXTRA_FRAC));
	assign t_sh     = t_full >>> (EXTRA_FRAC + 1);
	assign reach_s  = $signed({{(ANS_W-REACH_W){1'b0}}, reach_q});

	always_comb begin
		if (ans_q > reach_s) begin
			clamp_n = reach_s;
		end else if (ans_q < -reach_s) begin
			clamp_n = -reach_s;
		end else begin
			clamp_n = ans_q;
		end
	end

	assign err = ERR_W'(res_q) - ERR_W'(going_q);

	always_comb begin
		if ((&err[ERR_W-1:CARRY_W-1]) || !(|err[ERR_W-1:CARRY_W-1])) begin
			err_sat = err[CARRY_W-1:0];
		end else if (err[ERR_W-1]) begin
			err_sat = $signed({1'b1, {(CARRY_W-1){1'b0}}});
		end else begin
			err_sat = $signed({1'b0, {(CARRY_W-1){1'b1}}});
		end
	end

	assign out_load  = (state_q == S_OUT) && (!out_valid_q || results.ready);
	assign div_start = (state_q == S_START);

	dnsq_rem_unit #(
		.NUM_W(NUM_W)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     (num_mag),
		.divisor (divisor),
		.stat    (div_stat),
		.rem     (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			enabled_q   <= ENABLED_RST;
			mode_q      <= MODE_RST;
			bits_q      <= BITS_RST;
			reach_q     <= REACH_RST;
			gen_q       <= GEN_RST;
			carried_q   <= '0;
			step_q      <= STEP_RST;
			shape_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (clr_acc) begin
						carried_q <= '0;
					end else if (smp_acc) begin
						shape_q <= enabled_q && (mode_q == MODE_SHAPED);
						if (!enabled_q) begin
							state_q <= S_OUT;
						end else if (mode_q == MODE_PLAIN) begin
							state_q <= S_PREP;
						end else begin
							state_q <= S_DRAW1;
						end
					end
				end
				S_DRAW1: begin
					gen_q   <= gen_next;
					state_q <= S_DRAW2;
				end
				S_DRAW2: begin
					gen_q   <= gen_next;
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_PREP;
				S_PREP: state_q <= (step_q == '0) ? S_CLAMP : S_START;
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: state_q <= S_ROUND;
				S_ROUND: state_q <= S_CLAMP;
				S_CLAMP: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						if (shape_q) begin
							carried_q <= err_sat;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (redesign) begin
				enabled_q <= en_n;
				mode_q    <= mode_n;
				bits_q    <= bits_n;
				reach_q   <= reach_n;
				step_q    <= step_n;
				carried_q <= '0;
			end
			if (seed_wr) begin
				gen_q <= seed_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (smp_acc) begin
			going_q <= going_n;
			res_q   <= ANS_W'(sample_s);
			prod_q  <= '0;
		end
		if (state_q == S_DRAW1) begin
			d1_q <= gen_next[GEN_W-1:DRAW_LO];
		end
		if (state_q == S_DRAW2) begin
			dsum_q <= dsum_n;
		end
		if (state_q == S_MUL) begin
			prod_q <= dsum_q * step_sx;
		end
		if (state_q == S_PREP) begin
			n_q   <= n_n;
			ans_q <= '0;
		end
		if (state_q == S_START) begin
			neg_q <= n_q[NUM_W-1];
		end
		if (state_q == S_FIX) begin
			r_q <= r_n;
		end
		if (state_q == S_ROUND) begin
			ans_q <= t_sh[ANS_W-1:0];
		end
		if (state_q == S_CLAMP) begin
			res_q <= clamp_n;
		end
		if (out_load) begin
			out_data_q <= res_q[SAMPLE_WIDTH-1:0];
		end
	end

	assign results.valid     = out_valid_q;
	assign results.quantised = out_data_q;

	a_carried_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr && !clr_acc && state_q != S_OUT |=> $stable(carried_q))
		else $error("carried error moved outside clear, redesign or result");

	a_gen_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr && state_q != S_DRAW1 && state_q != S_DRAW2 |=> $stable(gen_q))
		else $error("dither generator advanced outside a draw");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		smp_acc |=> state_q != S_IDLE && !items.ready)
		else $error("sample transaction did not start the sequencer");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_valid_q && !results.ready |=> state_q == S_OUT)
		else $error("result left final state while output register full");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import dnsq_pkg::*;

	localparam int SW            = SAMPLE_WIDTH_DEF;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASE_ITEMS   = 140;
	localparam int RANDOM_PHASES = 12;

	localparam logic [MODE_W-1:0]  MODE_UNDEFINED = 2'd3;
	localparam logic [REACH_W-1:0] REACH_MAX      = '1;
	localparam longint CARRY_HI = (longint'(1) << (SW + 1)) - 1;
	localparam longint CARRY_LO = -CARRY_HI - 1;

	typedef struct {
		logic                  kind;
		logic signed [SW-1:0]  sample;
	} quant_item_t;

	typedef struct {
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} reg_write_t;

	logic clk;
	logic arst_n;

	dnsq_cfg_if                      cfg_bus ();
	dnsq_in_if  #(.SAMPLE_WIDTH(SW)) item_bus ();
	dnsq_out_if #(.SAMPLE_WIDTH(SW)) result_bus ();

	dithered_noise_shaped_quantiser #(
		.SAMPLE_WIDTH(SW),
		.MAX_BITS(MAX_BITS_DEF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.items(item_bus),
		.results(result_bus)
	);

	// quantiser state as the bench sees it
	logic                enabled_q;
	logic [MODE_W-1:0]   mode_q;
	logic [BITS_W-1:0]   bits_q;
	logic [REACH_W-1:0]  reach_q;
	logic [GEN_W-1:0]    gen_q;
	logic [STEP_W-1:0]   step_q;
	longint              carried_q;

	quant_item_t          pending_items[$];
	reg_write_t           register_writes[$];
	logic signed [SW-1:0] expected_levels[$];

	int   sender_idle_pct;
	int   receiver_stall_pct;
	logic sender_hold;
	int   fault_count;

	function automatic longint floor_quot(input longint num, input longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q -= 1;
		return q;
	endfunction

	function automatic logic [GEN_W-1:0] advance_generator();
		gen_q ^= gen_q << 13;
		gen_q ^= gen_q >> 17;
		gen_q ^= gen_q << 5;
		return gen_q;
	endfunction

	function automatic void recompute_step();
		longint wide;
		wide = (longint'(reach_q) << EXTRA_FRAC) >> (bits_q - 1);
		step_q = wide[STEP_W-1:0];
		carried_q = 0;
	endfunction

	function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_ENABLED: begin
				enabled_q = value[0];
				recompute_step();
			end
			REG_MODE: begin
				if (value[MODE_W-1:0] <= MODE_SHAPED) begin
					mode_q = value[MODE_W-1:0];
					recompute_step();
				end
			end
			REG_BIT_COUNT: begin
				if (value[BITS_W-1:0] >= 1 && value[BITS_W-1:0] <= MAX_BITS_DEF) begin
					bits_q = value[BITS_W-1:0];
					recompute_step();
				end
			end
			REG_REACH: begin
				if (value[REACH_W-1:0] != '0) begin
					reach_q = value[REACH_W-1:0];
					recompute_step();
				end
			end
			REG_SEED: gen_q = (value == '0) ? GEN_RST : value;
			default: ;
		endcase
	endfunction

	function automatic void predict_item(input quant_item_t it);
		longint going, level, spread, step, ans28, ans20;
		logic [GEN_W-1:0] g1, g2;
		if (it.kind == KIND_CLEAR) begin
			carried_q = 0;
			return;
		end
		if (!enabled_q) begin
			expected_levels.push_back(it.sample);
			return;
		end
		going = longint'(it.sample);
		if (mode_q == MODE_SHAPED)
			going -= carried_q;
		level = going * (longint'(1) << EXTRA_FRAC);
		step = longint'(step_q);
		if (mode_q != MODE_PLAIN) begin
			g1 = advance_generator();
			g2 = advance_generator();
			spread = longint'(g1 >> 8) + longint'(g2 >> 8) - (longint'(1) << 24);
			level += floor_quot(spread * step, longint'(1) << 24);
		end
		if (step == 0)
			ans28 = 0;
		else
			ans28 = floor_quot(2 * level + step, 2 * step) * step;
		ans20 = floor_quot(ans28 + (longint'(1) << (EXTRA_FRAC - 1)),
			longint'(1) << EXTRA_FRAC);
		if (ans20 > longint'(reach_q))
			ans20 = longint'(reach_q);
		if (ans20 < -longint'(reach_q))
			ans20 = -longint'(reach_q);
		if (mode_q == MODE_SHAPED) begin
			carried_q = ans20 - going;
			if (carried_q > CARRY_HI)
				carried_q = CARRY_HI;
			if (carried_q < CARRY_LO)
				carried_q = CARRY_LO;
		end
		expected_levels.push_back(SW'(ans20));
	endfunction

	function automatic void log_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic void queue_sample(input longint v);
		quant_item_t it;
		it.kind = KIND_SAMPLE;
		it.sample = SW'(v);
		pending_items.push_back(it);
	endfunction

	function automatic void queue_clear();
		quant_item_t it;
		it.kind = KIND_CLEAR;
		it.sample = SW'($urandom);
		pending_items.push_back(it);
	endfunction

	function automatic void plan_write(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		reg_write_t w;
		w.index = idx;
		w.data = value;
		register_writes.push_back(w);
	endfunction

	function automatic logic signed [SW-1:0] pick_sample(input logic [REACH_W-1:0] lim);
		longint v;
		case ($urandom_range(5))
			0, 1: v = longint'($urandom);
			2: begin
				v = longint'(lim) + longint'($urandom_range(512)) - 256;
				if ($urandom_range(1))
					v = -v;
			end
			3: v = longint'($urandom_range(4096)) - 2048;
			4: v = $urandom_range(1) ? (longint'(1) << (SW - 1)) - 1 : -(longint'(1) << (SW - 1));
			default: v = longint'($urandom_range(2 * lim)) - longint'(lim);
		endcase
		return SW'(v);
	endfunction

	function automatic void plan_random_setting();
		logic [CFG_DATA_W-1:0] d;
		d = $urandom;
		d[0] = ($urandom_range(9) != 0);
		plan_write(REG_ENABLED, d);
		d = $urandom;
		d[MODE_W-1:0] = ($urandom_range(9) == 0) ? MODE_UNDEFINED : MODE_W'($urandom_range(2));
		plan_write(REG_MODE, d);
		d = $urandom;
		case ($urandom_range(5))
			0: d[BITS_W-1:0] = BITS_W'(1);
			1: d[BITS_W-1:0] = BITS_W'(MAX_BITS_DEF);
			2: d[BITS_W-1:0] = BITS_W'($urandom_range(31));
			default: d[BITS_W-1:0] = BITS_W'($urandom_range(1, MAX_BITS_DEF));
		endcase
		plan_write(REG_BIT_COUNT, d);
		d = $urandom;
		case ($urandom_range(6))
			0: d[REACH_W-1:0] = REACH_W'(1);
			1: d[REACH_W-1:0] = REACH_MAX;
			2: d[REACH_W-1:0] = REACH_W'(1) << $urandom_range(REACH_W - 1);
			3: d[REACH_W-1:0] = '0;
			default: d[REACH_W-1:0] = REACH_W'($urandom_range(1, REACH_MAX));
		endcase
		plan_write(REG_REACH, d);
		if ($urandom_range(1))
			plan_write(REG_SEED, ($urandom_range(7) == 0) ? '0 : CFG_DATA_W'($urandom));
		if ($urandom_range(3) == 0)
			plan_write(REG_SEED + CFG_INDEX_W'($urandom_range(1, 3)), $urandom);
	endfunction

	task automatic commit_writes();
		while (register_writes.size() != 0 || cfg_bus.valid)
			@(posedge clk);
	endtask

	task automatic drain_and_settle();
		while (pending_items.size() != 0 || item_bus.valid || expected_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		sender_idle_pct <= send_pct;
		receiver_stall_pct <= stall_pct;
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("CHECK FAILED");
		$finish;
	end

	// item driver
	always @(posedge clk or negedge arst_n) begin : item_driver
		quant_item_t next_item;
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
			item_bus.kind <= KIND_SAMPLE;
			item_bus.sample <= '0;
		end else begin
			if (item_bus.valid && item_bus.ready) begin
				next_item.kind = item_bus.kind;
				next_item.sample = item_bus.sample;
				predict_item(next_item);
			end
			if (!item_bus.valid || item_bus.ready) begin
				if (pending_items.size() != 0 && !sender_hold &&
						int'($urandom_range(99)) >= sender_idle_pct) begin
					next_item = pending_items.pop_front();
					item_bus.valid <= 1'b1;
					item_bus.kind <= next_item.kind;
					item_bus.sample <= next_item.sample;
				end else begin
					item_bus.valid <= 1'b0;
				end
			end
		end
	end

	// register write driver
	always @(posedge clk or negedge arst_n) begin : cfg_driver
		reg_write_t w;
		if (!arst_n) begin
			cfg_bus.valid <= 1'b0;
			cfg_bus.index <= '0;
			cfg_bus.data <= '0;
		end else begin
			if (cfg_bus.valid && cfg_bus.ready)
				apply_register(cfg_bus.index, cfg_bus.data);
			if (!cfg_bus.valid || cfg_bus.ready) begin
				if (register_writes.size() != 0) begin
					w = register_writes.pop_front();
					cfg_bus.valid <= 1'b1;
					cfg_bus.index <= w.index;
					cfg_bus.data <= w.data;
				end else begin
					cfg_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : result_monitor
		logic signed [SW-1:0] wanted;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				if (expected_levels.size() == 0) begin
					log_fault($sformatf("unexpected result: quantised %0d", result_bus.quantised));
				end else begin
					wanted = expected_levels.pop_front();
					if (result_bus.quantised !== wanted)
						log_fault($sformatf("quantised mismatch: expected %0d, actual %0d",
							wanted, result_bus.quantised));
				end
			end
			result_bus.ready <= (int'($urandom_range(99)) >= receiver_stall_pct);
		end
	end

	initial begin
		int phase;
		int n;
		int k;
		arst_n = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		sender_hold = 1'b0;
		fault_count = 0;
		enabled_q = ENABLED_RST;
		mode_q = MODE_RST;
		bits_q = BITS_RST;
		reach_q = REACH_RST;
		gen_q = GEN_RST;
		step_q = STEP_RST;
		carried_q = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// disabled after reset: pass through
		queue_sample((longint'(1) << (SW - 1)) - 1);
		queue_sample(-(longint'(1) << (SW - 1)));
		queue_sample(0);
		queue_clear();
		drain_and_settle();

		// dither at reset resolution
		plan_write(REG_ENABLED, 32'd1);
		commit_writes();
		queue_sample((longint'(1) << (SW - 1)) - 1);
		queue_sample(-(longint'(1) << (SW - 1)));
		queue_sample(0);
		queue_sample(-1);
		queue_sample(1);
		drain_and_settle();

		// plain rounding
		plan_write(REG_MODE, CFG_DATA_W'(MODE_PLAIN));
		commit_writes();
		queue_sample(524288);
		queue_sample(-524289);
		queue_sample(12345);
		drain_and_settle();

		// shaping with a zero seed, clear between samples
		plan_write(REG_MODE, CFG_DATA_W'(MODE_SHAPED));
		plan_write(REG_SEED, '0);
		commit_writes();
		queue_sample(1000);
		queue_sample(1000);
		queue_clear();
		queue_sample(1000);
		queue_sample(-(longint'(1) << (SW - 1)));
		drain_and_settle();

		// zero step
		plan_write(REG_REACH, 32'd1);
		plan_write(REG_BIT_COUNT, MAX_BITS_DEF);
		plan_write(REG_MODE, CFG_DATA_W'(MODE_DITHER));
		commit_writes();
		queue_sample((longint'(1) << (SW - 1)) - 1);
		queue_sample(-5);
		drain_and_settle();

		// rejected writes and unused indexes
		plan_write(REG_MODE, {30'h3FFF_FFFF, MODE_UNDEFINED});
		plan_write(REG_BIT_COUNT, 32'd0);
		plan_write(REG_BIT_COUNT, MAX_BITS_DEF + 1);
		plan_write(REG_BIT_COUNT, 32'h0000_001F);
		plan_write(REG_REACH, {9'h1FF, 23'd0});
		for (k = 1; k <= 3; k++)
			plan_write(REG_SEED + CFG_INDEX_W'(k), $urandom);
		commit_writes();
		queue_sample(100);
		queue_sample(-100);
		drain_and_settle();

		// coarsest resolution at full reach
		plan_write(REG_BIT_COUNT, 32'd1);
		plan_write(REG_REACH, {9'd0, REACH_MAX});
		plan_write(REG_MODE, CFG_DATA_W'(MODE_SHAPED));
		commit_writes();
		queue_sample((longint'(1) << (SW - 1)) - 1);
		queue_sample(-(longint'(1) << (SW - 1)));
		queue_sample(3000000);
		drain_and_settle();

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			plan_random_setting();
			commit_writes();
			case (phase % 4)
				0: set_idling(0, 0);
				1: set_idling(63, 0);
				2: set_idling(0, 63);
				default: set_idling(22, 22);
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 5 && n == PHASE_ITEMS / 2) begin
					// hold the sender until every result is back
					while (pending_items.size() != 0)
						@(posedge clk);
					sender_hold <= 1'b1;
					@(posedge clk);
					while (item_bus.valid || expected_levels.size() != 0)
						@(posedge clk);
				end
				if ($urandom_range(19) == 0)
					queue_clear();
				else
					queue_sample(pick_sample(reach_q));
			end
			sender_hold <= 1'b0;
			drain_and_settle();
		end

		if (fault_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/dnsq_pkg.sv
rtl/dnsq_if.sv
rtl/dnsq_rem_unit.sv
rtl/dithered_noise_shaped_quantiser.sv
bench/testbench.sv
